FILE: design/bta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types, register indexes and fixed-point helpers for the binomial
// tree pricer.
// ----------------------------------------------------------------------------
package bta_pkg;

    localparam int PRICE_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [2*PRICE_W-1:0] prod_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UP_FACTOR   = 3'd0,
        REG_DOWN_FACTOR = 3'd1,
        REG_UP_PROB     = 3'd2,
        REG_DOWN_PROB   = 3'd3,
        REG_STEP_DISC   = 3'd4,
        REG_NODE_COUNT  = 3'd5,
        REG_TREE_STATUS = 3'd6,
        REG_UNUSED      = 3'd7
    } cfg_reg_t;

    localparam logic [1:0] STATUS_NORMAL  = 2'd0;
    localparam logic [1:0] STATUS_EXPIRED = 2'd1;

    localparam logic KIND_PUT = 1'b1;

    localparam logic [PRICE_W+2:0] HALF_Q30 = 35'h0_2000_0000;

    // Q30 rounding (ties up) and saturation of a 65-bit accumulation.
    function automatic price_t round_sat(input logic [2*PRICE_W:0] wide);
        logic [2*PRICE_W+1:0] sum;
        logic [2*PRICE_W-29:0] shifted;
        sum = {1'b0, wide} + {31'd0, HALF_Q30};
        shifted = sum[2*PRICE_W+1:30];
        if (|shifted[2*PRICE_W-29:PRICE_W])
            return '1;
        return shifted[PRICE_W-1:0];
    endfunction

    function automatic price_t payoff(input logic is_put, input price_t s, input price_t x);
        if (is_put == KIND_PUT)
            return (x > s) ? x - s : '0;
        return (s > x) ? s - x : '0;
    endfunction

endpackage

FILE: design/binomial_tree_american_option_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_tree_american_option_top
// American call/put pricer, backward induction over a CRR binomial tree.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg port: write u, d, p, q, discount, leaf count and status while idle.
//  - s_ channel: one option per transfer (tuser = kind, tdata = spot/strike).
//  - m_ channel: one option value per input transfer, Q16.16, saturated.
// Sequence, normal status, n = clamped leaf count:
//  - leaf build: spot*d^(n-1), then n leaves, each the last one times u twice
//  - induction: a read, multiply, round and discount pass per interior node, plus
//    a reload of the first value per level; the single read port of the value
//    memory and the multiply/round/discount chain of each node set its pace.
//  - expired status gives the payoff, invalid status zero, with no tree built.
// Items are processed one at a time; s_tready is high only when idle. A
// finished result sits in the output register, so the next item is taken
// while it waits; a second result waits inside until m_tready frees it.
// Reset returns the state to idle, clears the output valid and loads the config
// defaults; the node memories need no clearing, each written before it is read.
// ----------------------------------------------------------------------------
module binomial_tree_american_option_top #(
    parameter int MAX_NODES = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [bta_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bta_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,  // [31:0] spot_price, [63:32] strike_price
    input  logic                        s_tuser,  // [0] kind
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata   // [31:0] option_value
);
    import bta_pkg::*;

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1) + 1;
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_NODES);
    localparam logic [CNT_W-1:0] MIN_N = CNT_W'(2);

    typedef enum logic [4:0] {
        ST_IDLE, ST_START, ST_DN_MUL, ST_DN_RND, ST_LF_WR,
        ST_UP1, ST_UP1R, ST_UP2, ST_UP2R,
        ST_LVRD, ST_LVCAP, ST_RD, ST_M1, ST_M2, ST_M3, ST_M4, ST_FIN
    } state_t;

    // config registers
    logic [31:0] up_factor_reg;
    logic [30:0] down_factor_reg, up_prob_reg, down_prob_reg, step_disc_reg;
    logic [10:0] node_count_reg;
    logic [1:0]  tree_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_factor_reg   <= 32'h4000_0000;
            down_factor_reg <= 31'h4000_0000;
            up_prob_reg     <= 31'h2000_0000;
            down_prob_reg   <= 31'h2000_0000;
            step_disc_reg   <= 31'h4000_0000;
            node_count_reg  <= 11'd2;
            tree_status_reg <= STATUS_NORMAL;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_UP_FACTOR:   up_factor_reg   <= cfg_wdata;
                REG_DOWN_FACTOR: down_factor_reg <= cfg_wdata[30:0];
                REG_UP_PROB:     up_prob_reg     <= cfg_wdata[30:0];
                REG_DOWN_PROB:   down_prob_reg   <= cfg_wdata[30:0];
                REG_STEP_DISC:   step_disc_reg   <= cfg_wdata[30:0];
                REG_NODE_COUNT:  node_count_reg  <= cfg_wdata[10:0];
                REG_TREE_STATUS: tree_status_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // clamped leaf count
    logic [CNT_W-1:0] n_raw, n_clamp;
    assign n_raw = CNT_W'(node_count_reg);
    always_comb begin
        priority if (n_raw < MIN_N) n_clamp = MIN_N;
        else if (n_raw > MAX_N)     n_clamp = MAX_N;
        else                        n_clamp = n_raw;
    end

    state_t           state_reg;
    logic             kind_reg;
    price_t           spot_reg, strike_reg;
    logic [CNT_W-1:0] n_reg, k_reg, cnt_reg;
    logic [IDX_W-1:0] l_reg;
    price_t           lead_reg, va_reg, cont_in_reg, newp_reg, result_reg;
    prod_t            prod_a_reg, prod_b_reg, prod_c_reg;
    logic             m_valid_reg;
    price_t           m_data_reg;

    // node memories, one write and one read port each, registered read
    price_t prices_mem [MAX_NODES];
    price_t values_mem [MAX_NODES];
    price_t prices_rd, values_rd;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr, vrd_addr;
    price_t           wr_price, wr_value;

    // shared multiplier for price and discount products
    price_t mul_a, mul_b;
    always_comb begin
        unique case (state_reg)
            ST_M1:   mul_a = prices_rd;
            ST_M3:   mul_a = cont_in_reg;
            default: mul_a = lead_reg;
        endcase
        unique case (state_reg)
            ST_DN_MUL: mul_b = {1'b0, down_factor_reg};
            ST_M3:     mul_b = {1'b0, step_disc_reg};
            default:   mul_b = up_factor_reg;
        endcase
    end

    price_t cont, ex, node_val;
    assign cont     = round_sat({1'b0, prod_c_reg});
    assign ex       = payoff(kind_reg, newp_reg, strike_reg);
    assign node_val = (cont > ex) ? cont : ex;

    logic [CNT_W-1:0] l_ext;
    assign l_ext = CNT_W'(l_reg);

    always_comb begin
        mem_we   = 1'b0;
        wr_addr  = cnt_reg[IDX_W-1:0];
        wr_price = lead_reg;
        wr_value = payoff(kind_reg, lead_reg, strike_reg);
        vrd_addr = l_reg + IDX_W'(1);
        if (state_reg == ST_LF_WR)
            mem_we = 1'b1;
        if (state_reg == ST_M4) begin
            mem_we   = 1'b1;
            wr_addr  = l_reg;
            wr_price = newp_reg;
            wr_value = node_val;
        end
        if (state_reg == ST_LVRD)
            vrd_addr = '0;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            prices_mem[wr_addr] <= wr_price;
            values_mem[wr_addr] <= wr_value;
        end
        prices_rd <= prices_mem[l_reg];
        values_rd <= values_mem[vrd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // the finish state reloads the output register itself
            if (m_valid_reg && m_tready && state_reg != ST_FIN)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg   <= s_tuser;
                        spot_reg   <= s_tdata[31:0];
                        strike_reg <= s_tdata[63:32];
                        state_reg  <= ST_START;
                    end
                end
                ST_START: begin
                    n_reg    <= n_clamp;
                    lead_reg <= spot_reg;
                    cnt_reg  <= CNT_W'(1);
                    if (tree_status_reg == STATUS_NORMAL) begin
                        state_reg <= ST_DN_MUL;
                    end else begin
                        result_reg <= (tree_status_reg == STATUS_EXPIRED)
                                      ? payoff(kind_reg, spot_reg, strike_reg) : '0;
                        state_reg  <= ST_FIN;
                    end
                end
                ST_DN_MUL: begin
                    prod_c_reg <= mul_a * mul_b;
                    state_reg  <= ST_DN_RND;
                end
                ST_DN_RND: begin
                    lead_reg <= cont;
                    if (cnt_reg == n_reg - CNT_W'(1)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_LF_WR;
                    end else begin
                        cnt_reg   <= cnt_reg + CNT_W'(1);
                        state_reg <= ST_DN_MUL;
                    end
                end
                ST_LF_WR: begin
                    if (cnt_reg == n_reg - CNT_W'(1)) begin
                        k_reg     <= n_reg;
                        state_reg <= ST_LVRD;
                    end else begin
                        state_reg <= ST_UP1;
                    end
                end
                ST_UP1: begin
                    prod_c_reg <= mul_a * mul_b;
                    state_reg  <= ST_UP1R;
                end
                ST_UP1R: begin
                    lead_reg  <= cont;
                    state_reg <= ST_UP2;
                end
                ST_UP2: begin
                    prod_c_reg <= mul_a * mul_b;
                    state_reg  <= ST_UP2R;
                end
                ST_UP2R: begin
                    lead_reg  <= cont;
                    cnt_reg   <= cnt_reg + CNT_W'(1);
                    state_reg <= ST_LF_WR;
                end
                ST_LVRD: begin
                    l_reg     <= '0;
                    state_reg <= ST_LVCAP;
                end
                ST_LVCAP: begin
                    va_reg    <= values_rd;
                    state_reg <= ST_RD;
                end
                ST_RD: state_reg <= ST_M1;
                ST_M1: begin
                    prod_a_reg <= {1'b0, down_prob_reg} * va_reg;
                    prod_b_reg <= {1'b0, up_prob_reg} * values_rd;
                    prod_c_reg <= mul_a * mul_b;
                    va_reg     <= values_rd;
                    state_reg  <= ST_M2;
                end
                ST_M2: begin
                    cont_in_reg <= round_sat({1'b0, prod_a_reg} + {1'b0, prod_b_reg});
                    newp_reg    <= cont;
                    state_reg   <= ST_M3;
                end
                ST_M3: begin
                    prod_c_reg <= mul_a * mul_b;
                    state_reg  <= ST_M4;
                end
                ST_M4: begin
                    if (l_ext + CNT_W'(2) < k_reg) begin
                        l_reg     <= l_reg + IDX_W'(1);
                        state_reg <= ST_RD;
                    end else if (k_reg == MIN_N) begin
                        result_reg <= node_val;
                        state_reg  <= ST_FIN;
                    end else begin
                        k_reg     <= k_reg - CNT_W'(1);
                        state_reg <= ST_LVRD;
                    end
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= result_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    logic in_back;
    assign in_back = (state_reg == ST_RD) || (state_reg == ST_M1) || (state_reg == ST_M2)
                  || (state_reg == ST_M3) || (state_reg == ST_M4);

    a_node_in_level: assert property (@(posedge aclk) disable iff (!aresetn)
        in_back |-> (l_ext + CNT_W'(1) < k_reg))
        else $error("node index outside current level");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_back |-> (k_reg >= MIN_N && k_reg <= n_reg))
        else $error("level count out of range");

    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_START))
        else $error("accepted item did not start");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result loaded outside finish state");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binomial tree American option pricer. A
// bit-exact predictor mirrors the register file and computes the expected
// root value for each accepted option. Results are checked in order while
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import bta_pkg::*;

    localparam int NODES_MAX = 1024;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [1:0] STATUS_INVALID = 2'd2;
    localparam logic [1:0] STATUS_SPARE = 2'd3;  // undefined code, acts as invalid
    localparam logic KIND_CALL = 1'b0;
    localparam longint CYCLE_LIMIT = 20_000_000;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    logic [63:0] s_tdata;   // [31:0] spot_price, [63:32] strike_price
    logic s_tuser;          // [0] kind
    logic m_tvalid;
    logic m_tready;
    logic [31:0] m_tdata;   // [31:0] option_value

    binomial_tree_american_option_top #(.MAX_NODES(NODES_MAX)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Shadow copy of the register file
    logic [31:0] sh_up, sh_down, sh_pu, sh_pd, sh_disc;
    logic [10:0] sh_nodes;
    logic [1:0]  sh_status;

    logic [31:0] expected_values[$];
    int  error_count = 0;
    int  max_gap = 17;        // 0 gives a stretch with no idling
    bit  hold_off_req = 0;    // asks the receiver for one long stall
    longint cycle_count = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] q30_round(input logic [64:0] wide);
        logic [65:0] r;
        r = ({1'b0, wide} + 66'h2000_0000) >> 30;
        return (r > 66'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic logic [31:0] q30_mul(input logic [31:0] a, input logic [31:0] f);
        return q30_round({1'b0, 64'(a) * 64'(f)});
    endfunction

    function automatic logic [31:0] exercise(input logic put, input logic [31:0] s,
                                             input logic [31:0] x);
        if (put) return (x > s) ? x - s : 32'd0;
        return (s > x) ? s - x : 32'd0;
    endfunction

    function automatic logic [31:0] price_option(input logic put, input logic [31:0] s,
                                                 input logic [31:0] x);
        logic [31:0] px[NODES_MAX];
        logic [31:0] vx[NODES_MAX];
        logic [31:0] lead, cont, ex;
        logic [64:0] acc;
        int n;
        if (sh_status == STATUS_EXPIRED) return exercise(put, s, x);
        if (sh_status != STATUS_NORMAL) return 32'd0;
        n = sh_nodes;
        if (n < 2) n = 2;
        if (n > NODES_MAX) n = NODES_MAX;
        lead = s;
        for (int i = 1; i < n; i++) lead = q30_mul(lead, sh_down);
        px[0] = lead;
        vx[0] = exercise(put, lead, x);
        for (int i = 1; i < n; i++) begin
            px[i] = q30_mul(q30_mul(px[i-1], sh_up), sh_up);
            vx[i] = exercise(put, px[i], x);
        end
        // backward induction, early exercise floor at each node
        for (int k = n; k >= 2; k--) begin
            for (int l = 0; l + 1 < k; l++) begin
                acc = 65'(64'(sh_pd) * 64'(vx[l])) + 65'(64'(sh_pu) * 64'(vx[l+1]));
                cont = q30_mul(q30_round(acc), sh_disc);
                px[l] = q30_mul(px[l], sh_up);
                ex = exercise(put, px[l], x);
                vx[l] = (cont > ex) ? cont : ex;
            end
        end
        return vx[0];
    endfunction

    // ------------------------------------------------------------------
    // Drivers; every task starts and ends just after a rising edge
    // ------------------------------------------------------------------
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_UP_FACTOR:   sh_up = val;
            REG_DOWN_FACTOR: sh_down = {1'b0, val[30:0]};
            REG_UP_PROB:     sh_pu = {1'b0, val[30:0]};
            REG_DOWN_PROB:   sh_pd = {1'b0, val[30:0]};
            REG_STEP_DISC:   sh_disc = {1'b0, val[30:0]};
            REG_NODE_COUNT:  sh_nodes = val[10:0];
            REG_TREE_STATUS: sh_status = val[1:0];
            default: ;       // unused index is ignored
        endcase
        @(posedge aclk);
    endtask

    // One option transfer; valid stays up after acceptance until the next gap.
    task automatic send_option(input logic put, input logic [31:0] spot,
                               input logic [31:0] strike);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= put;
        s_tdata  <= {strike, spot};
        do @(posedge aclk); while (!s_tready);
        expected_values.push_back(price_option(put, spot, strike));
    endtask

    // Drop valid and wait for every pending result, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_tree(input logic [31:0] u, input logic [31:0] d,
                              input logic [31:0] p, input logic [31:0] q,
                              input logic [31:0] disc, input logic [31:0] nodes,
                              input logic [1:0] status);
        write_reg(REG_UP_FACTOR, u);
        write_reg(REG_DOWN_FACTOR, d);
        write_reg(REG_UP_PROB, p);
        write_reg(REG_DOWN_PROB, q);
        write_reg(REG_STEP_DISC, disc);
        write_reg(REG_NODE_COUNT, nodes);
        write_reg(REG_TREE_STATUS, 32'(status));
    endtask

    // ------------------------------------------------------------------
    // Result checker with random stalls and one requested long hold-off
    // ------------------------------------------------------------------
    initial begin
        int stall;
        logic [31:0] want;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = hold_off_req ? 400 : $urandom_range(0, max_gap);
            if (hold_off_req) hold_off_req = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (expected_values.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_values.pop_front();
                if (m_tdata !== want) begin
                    $display("%0t: option_value mismatch, expected %h, actual %h",
                             $time, want, m_tdata);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_config();
        // u = d = 1, two leaves, even odds
        send_option(KIND_CALL, 32'h0010_0000, 32'h000C_0000);
        send_option(KIND_PUT, 32'h0010_0000, 32'h0018_0000);
        drain();
    endtask

    task automatic test_expired();
        write_reg(REG_TREE_STATUS, 32'(STATUS_EXPIRED));
        send_option(KIND_CALL, 32'hFFFF_FFFF, 32'h0000_0000);
        send_option(KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_option(KIND_CALL, 32'h0000_0000, 32'hFFFF_FFFF);
        send_option(KIND_PUT, 32'h1234_5678, 32'h1234_5678);
        drain();
    endtask

    task automatic test_invalid();
        write_reg(REG_TREE_STATUS, 32'(STATUS_INVALID));
        send_option(KIND_CALL, 32'hFFFF_FFFF, 32'h0000_0001);
        send_option(KIND_PUT, 32'h0000_0001, 32'hFFFF_FFFF);
        drain();
        write_reg(REG_TREE_STATUS, 32'(STATUS_SPARE));
        send_option(KIND_CALL, 32'hFFFF_FFFF, 32'h0000_0000);
        drain();
    endtask

    task automatic test_typical_tree();
        // u ~ 1.01, d ~ 1/u, p ~ 0.52, small discount
        write_tree(32'h40A3_D70A, 32'h3F5E_9AA8, 32'h2147_AE14, 32'h1EB8_51EC,
                   32'h3FFF_0000, 8, STATUS_NORMAL);
        send_option(KIND_CALL, 32'h0064_0000, 32'h0064_0000);
        send_option(KIND_PUT, 32'h0064_0000, 32'h006E_0000);
        send_option(KIND_CALL, 32'hFFFF_FFFF, 32'h0000_0000);
        send_option(KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_saturating_tree();
        // inconsistent, oversized factors: products must saturate, not wrap
        write_tree(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 4, STATUS_NORMAL);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_option(KIND_CALL, 32'hFFFF_FFFF, 32'h0000_0001);
        send_option(KIND_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
        drain();
        write_tree(ONE_Q30, 32'd0, 32'd0, 32'd0, 32'd0, 3, STATUS_NORMAL);
        send_option(KIND_PUT, 32'h0001_0000, 32'h0002_0000);
        drain();
    endtask

    task automatic test_node_clamp();
        write_tree(32'h4051_EB85, 32'h3FAF_4A4F, 32'h2000_0000, 32'h2000_0000,
                   32'h3FFF_F000, 0, STATUS_NORMAL);
        send_option(KIND_PUT, 32'h0064_0000, 32'h0065_0000);
        drain();
        write_reg(REG_NODE_COUNT, 1);
        send_option(KIND_CALL, 32'h0064_0000, 32'h0063_0000);
        drain();
        // above the limit: runs the deepest tree once
        write_reg(REG_NODE_COUNT, 2047);
        send_option(KIND_PUT, 32'h0064_0000, 32'h0064_0000);
        drain();
    endtask

    task automatic test_back_pressure();
        write_tree(32'h4100_0000, 32'h3F03_F040, 32'h2200_0000, 32'h1E00_0000,
                   32'h3FF0_0000, 5, STATUS_NORMAL);
        max_gap = 0;
        hold_off_req = 1;
        repeat (5) send_option(1'($urandom_range(0, 1)), $urandom, $urandom);
        max_gap = 17;
        // sender pauses until every result is back
        drain();
    endtask

    task automatic test_random();
        logic [31:0] u, p;
        int kind_sel;
        for (int phase = 0; phase < 10; phase++) begin
            max_gap = (phase % 4 == 3) ? 0 : 17;
            kind_sel = $urandom_range(0, 9);
            if (kind_sel == 0) begin
                write_tree($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(0, 12), 2'($urandom_range(0, 3)));
            end else begin
                u = ONE_Q30 + $urandom_range(0, 32'h0800_0000);
                p = $urandom_range(0, ONE_Q30);
                write_tree(u, 32'((64'h1 << 60) / u), p, ONE_Q30 - p,
                           ONE_Q30 - $urandom_range(0, 32'h0010_0000),
                           $urandom_range(2, 12),
                           (kind_sel == 1) ? STATUS_EXPIRED : STATUS_NORMAL);
            end
            for (int i = 0; i < 8; i++) begin
                if ($urandom_range(0, 3) == 0)
                    send_option(1'($urandom_range(0, 1)), $urandom, $urandom);
                else
                    // near the money, where exercise and continuation compete
                    send_option(1'($urandom_range(0, 1)),
                                32'h0064_0000 + $urandom_range(0, 32'h003F_FFFF),
                                32'h0064_0000 + $urandom_range(0, 32'h003F_FFFF));
            end
            drain();
        end
        max_gap = 17;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        sh_up = ONE_Q30;
        sh_down = ONE_Q30;
        sh_pu = 32'h2000_0000;
        sh_pd = 32'h2000_0000;
        sh_disc = ONE_Q30;
        sh_nodes = 11'd2;
        sh_status = STATUS_NORMAL;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_config();
        test_expired();
        test_invalid();
        test_typical_tree();
        test_saturating_tree();
        test_node_clamp();
        test_back_pressure();
        test_random();

        drain();
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/bta_pkg.sv
design/binomial_tree_american_option_top.sv
tb/tb.sv
